### src/sasmt_pkg.sv
// ----------------------------------------------------------------------------
// sasmt_pkg
// Shared types and codes for the sorted address set with largest-address
// tracker: item structs, status codes and controller/datapath buses.
// ----------------------------------------------------------------------------
package sasmt_pkg;

   // operation codes
   localparam logic OP_ADD = 1'b0;
   localparam logic OP_DEL = 1'b1;

   // status codes
   localparam logic [2:0] ST_ADDED     = 3'd0;
   localparam logic [2:0] ST_DUPLICATE = 3'd1;
   localparam logic [2:0] ST_DELETED   = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   // input item
   typedef struct packed {
      logic        operation;
      logic [31:0] address;
   } req_type;

   // result item
   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] largest_address;
      logic        identifier_changed;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       apply_add;
      logic       apply_del;
      logic       respond;
      logic [2:0] status;
      logic       changed;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic any_match;
      logic full;
      logic head_greater;
      logic head_match;
      logic multi;
   } dp_stat_type;

endpackage

### src/sasmt_datapath.sv
// ----------------------------------------------------------------------------
// sasmt_datapath
// Chain of address cells kept in descending order, with per-cell compare
// flags, entry count and the registered result item.
// ----------------------------------------------------------------------------
module sasmt_datapath import sasmt_pkg::*; #(
   parameter int SET_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_item,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   output rsp_type     rsp_item
);

   localparam int CW = $clog2(SET_DEPTH + 1);

   logic [31:0]          entry_ff [SET_DEPTH];
   logic [31:0]          entry_in [SET_DEPTH];
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        count_in;
   logic [31:0]          addr_ff;
   logic [SET_DEPTH-1:0] gt_ff;
   logic [SET_DEPTH-1:0] eq_ff;
   rsp_type              rsp_ff;

   // per-cell compare against the incoming address, captured at accept
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff <= req_item.address;
         for (int i = 0; i < SET_DEPTH; i++) begin
            gt_ff[i] <= (CW'(i) < count_ff) && (entry_ff[i] > req_item.address);
            eq_ff[i] <= (CW'(i) < count_ff) && (entry_ff[i] == req_item.address);
         end
      end
   end

   // next value of each cell: keep, take the new address, or shift
   genvar g;
   generate
      for (g = 0; g < SET_DEPTH; g++) begin : g_cell
         logic [31:0] add_val;
         logic [31:0] del_val;
         if (g == 0) begin : g_first
            assign add_val = addr_ff;
         end else begin : g_rest
            assign add_val = gt_ff[g-1] ? addr_ff : entry_ff[g-1];
         end
         if (g == SET_DEPTH - 1) begin : g_last
            assign del_val = entry_ff[g];
         end else begin : g_inner
            assign del_val = entry_ff[g+1];
         end
         always_comb begin
            entry_in[g] = entry_ff[g];
            if (cmd.apply_add && !gt_ff[g]) begin
               entry_in[g] = add_val;
            end else if (cmd.apply_del && !gt_ff[g]) begin
               entry_in[g] = del_val;
            end
         end
      end
   endgenerate

   // entry count
   always_comb begin
      count_in = count_ff;
      if (cmd.apply_add) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.apply_del) begin
         count_in = count_ff - CW'(1);
      end
   end

   // cell storage, no reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < SET_DEPTH; i++) begin
         entry_ff[i] <= entry_in[i];
      end
   end

   // count and result item
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_ff.status             <= cmd.status;
         rsp_ff.largest_address    <= (count_in != '0) ? entry_in[0] : 32'd0;
         rsp_ff.identifier_changed <= cmd.changed;
      end
   end

   // status toward the controller
   assign stat.any_match    = |eq_ff;
   assign stat.full         = (count_ff == CW'(SET_DEPTH));
   assign stat.head_greater = gt_ff[0];
   assign stat.head_match   = eq_ff[0];
   assign stat.multi        = (count_ff > CW'(1));

   assign rsp_item = rsp_ff;

endmodule

### src/sasmt_controller.sv
// ----------------------------------------------------------------------------
// sasmt_controller
// Two-state sequencer: captures an item, then decides the outcome and
// drives the cell update and the result strobe.
// ----------------------------------------------------------------------------
module sasmt_controller import sasmt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        operation,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd,
   output logic        busy,
   output logic        rsp_strobe
);

   typedef enum logic {
      S_IDLE,
      S_UPDATE
   } state_type;

   state_type state_ff;
   logic      op_ff;
   logic      rsp_strobe_ff;
   logic      load;

   assign load = start && (state_ff == S_IDLE);

   // state, captured operation and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         op_ff         <= OP_ADD;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (state_ff == S_UPDATE);
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  op_ff    <= operation;
                  state_ff <= S_UPDATE;
               end
            end
            S_UPDATE: begin
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // outcome decision from the compare flags
   always_comb begin
      cmd           = '0;
      cmd.load      = load;
      cmd.status    = ST_NOT_FOUND;
      if (state_ff == S_UPDATE) begin
         cmd.respond = 1'b1;
         if (op_ff == OP_ADD) begin
            if (stat.any_match) begin
               cmd.status = ST_DUPLICATE;
            end else if (stat.full) begin
               cmd.status = ST_FULL;
            end else begin
               cmd.status    = ST_ADDED;
               cmd.apply_add = 1'b1;
               cmd.changed   = !stat.head_greater;
            end
         end else begin
            if (stat.any_match) begin
               cmd.status    = ST_DELETED;
               cmd.apply_del = 1'b1;
               cmd.changed   = stat.head_match && stat.multi;
            end else begin
               cmd.status = ST_NOT_FOUND;
            end
         end
      end
   end

   assign busy       = (state_ff == S_UPDATE);
   assign rsp_strobe = rsp_strobe_ff;

`ifndef SYNTHESIS
   // an accepted item moves to the update step
   a_load_update: assert property (@(posedge clock) disable iff (reset)
      load |=> (state_ff == S_UPDATE))
      else $error("accepted item did not enter update");

   // update step always yields exactly one result next cycle
   a_update_strobe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) |=> (rsp_strobe_ff && (state_ff == S_IDLE)))
      else $error("update step without result strobe");

   // no result without an update step before it
   a_strobe_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == S_UPDATE))
      else $error("result strobe without update step");

   // add and delete never applied together
   a_single_apply: assert property (@(posedge clock) disable iff (reset)
      !(cmd.apply_add && cmd.apply_del))
      else $error("add and delete applied together");
`endif

endmodule

### src/sorted_address_set_max_tracker_core.sv
// ----------------------------------------------------------------------------
// sorted_address_set_max_tracker_core
// Set of distinct 32-bit addresses held in descending order in a chain of
// cells; each add or delete answers with a status, the largest address and
// an identifier-changed flag.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   start / busy         req_item   (req_type)
//  response  rsp_strobe           rsp_item   (rsp_type)
//
//  each item is handled in order: the accept registers the per-cell compares,
//  then the update step shifts the cell chain and registers the result
//  busy is high for the one update cycle; the result strobe follows it for
//  one cycle, during which the next start is already taken
//  synchronous reset empties the set; cell contents are not cleared
//  the receiver takes each result in its strobe cycle and cannot stall
// ----------------------------------------------------------------------------
module sorted_address_set_max_tracker_core import sasmt_pkg::*; #(
   parameter int SET_DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer
   sasmt_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .operation  (req_item.operation),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // cell chain and result register
   sasmt_datapath #(
      .SET_DEPTH (SET_DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_item (rsp_item)
   );

endmodule
